// ----- hdl/receipt_tagged_store_assert.svh -----
// assertion macros used by the receipt store sequencer
`ifndef RECEIPT_TAGGED_STORE_ASSERT_SVH
`define RECEIPT_TAGGED_STORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("receipt store check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("receipt store check failed");

`endif

// ----- hdl/rts_pkg.sv -----
// shared types and constants of the receipt store
`default_nettype none
package rts_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int ITEM_WIDTH_DEF    = 32;
  localparam int RECEIPT_WIDTH_DEF = 16;

  // wide enough for a slot index at the largest supported capacity
  localparam int POS_W = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_t;

endpackage
`default_nettype wire

// ----- hdl/rts_cell.sv -----
// one slot of the store chain: item and receipt, shifted toward the head
`default_nettype none
module rts_cell #(
  parameter int IDX           = 0,
  parameter int ITEM_WIDTH    = rts_pkg::ITEM_WIDTH_DEF,
  parameter int RECEIPT_WIDTH = rts_pkg::RECEIPT_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire rts_pkg::cell_ctl_t  ctl,
  input  wire  [ITEM_WIDTH-1:0]    load_item,
  input  wire  [RECEIPT_WIDTH-1:0] load_rcpt,
  input  wire  [ITEM_WIDTH-1:0]    head_item,
  input  wire  [RECEIPT_WIDTH-1:0] head_rcpt,
  input  wire  [ITEM_WIDTH-1:0]    up_item,
  input  wire  [RECEIPT_WIDTH-1:0] up_rcpt,
  output logic [ITEM_WIDTH-1:0]    item,
  output logic [RECEIPT_WIDTH-1:0] rcpt
);
  import rts_pkg::*;

  logic [ITEM_WIDTH-1:0]    item_r, item_nxt;
  logic [RECEIPT_WIDTH-1:0] rcpt_r, rcpt_nxt;
  logic                     at_pos;

  assign at_pos = (ctl.pos == POS_W'(IDX));

  always_comb begin
    item_nxt = item_r;
    rcpt_nxt = rcpt_r;
    case (ctl.op)
      CELL_LOAD: begin
        if (at_pos) begin
          item_nxt = load_item;
          rcpt_nxt = load_rcpt;
        end
      end
      CELL_ROTATE: begin
        if (at_pos) begin
          item_nxt = head_item;
          rcpt_nxt = head_rcpt;
        end else begin
          item_nxt = up_item;
          rcpt_nxt = up_rcpt;
        end
      end
      CELL_DROP: begin
        item_nxt = up_item;
        rcpt_nxt = up_rcpt;
      end
      default: begin
        item_nxt = item_r;
        rcpt_nxt = rcpt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rcpt_r <= rcpt_nxt;
  end

  assign item = item_r;
  assign rcpt = rcpt_r;

endmodule
`default_nettype wire

// ----- hdl/rts_ctrl.sv -----
// sequencer: count, receipt counter, head compare and result registers
`default_nettype none
`include "receipt_tagged_store_assert.svh"
module rts_ctrl #(
  parameter int CAPACITY      = rts_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH    = rts_pkg::ITEM_WIDTH_DEF,
  parameter int RECEIPT_WIDTH = rts_pkg::RECEIPT_WIDTH_DEF,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire                      in_kind,
  input  wire  [RECEIPT_WIDTH-1:0] in_receipt,
  input  wire  [ITEM_WIDTH-1:0]    head_item,
  input  wire  [RECEIPT_WIDTH-1:0] head_rcpt,
  output rts_pkg::cell_ctl_t       cell_ctl,
  output logic [RECEIPT_WIDTH-1:0] load_rcpt,
  output logic                     out_valid,
  output logic [RECEIPT_WIDTH-1:0] out_issued_receipt,
  output logic [ITEM_WIDTH-1:0]    out_removed_item,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_item_count,
  output logic                     out_is_empty
);
  import rts_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  ctrl_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         steps_r, steps_nxt;
  logic [RECEIPT_WIDTH-1:0] next_rcpt_r, next_rcpt_nxt;
  logic [RECEIPT_WIDTH-1:0] rcpt_inc;
  logic [RECEIPT_WIDTH-1:0] key_r, key_nxt;
  logic                     found_r, found_nxt;
  logic [ITEM_WIDTH-1:0]    hit_r, hit_nxt;
  logic                     match;

  logic                     ov_r, ov_nxt;
  logic [RECEIPT_WIDTH-1:0] orc_r, orc_nxt;
  logic [ITEM_WIDTH-1:0]    oitem_r, oitem_nxt;
  logic [1:0]               ost_r, ost_nxt;
  logic [CNT_W-1:0]         ocnt_r, ocnt_nxt;

  assign rcpt_inc = next_rcpt_r + 1'b1;
  assign match    = !found_r && (head_rcpt == key_r);
  assign busy     = (state_r == ST_SCAN);
  assign load_rcpt = next_rcpt_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    next_rcpt_nxt = next_rcpt_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    ov_nxt        = 1'b0;
    orc_nxt       = orc_r;
    oitem_nxt     = oitem_r;
    ost_nxt       = ost_r;
    ocnt_nxt      = ocnt_r;
    cell_ctl.op   = CELL_HOLD;
    cell_ctl.pos  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_INSERT) begin
            ov_nxt    = 1'b1;
            oitem_nxt = '0;
            if (count_r == CAP_CNT) begin
              orc_nxt  = '0;
              ost_nxt  = STATUS_FULL;
              ocnt_nxt = count_r;
            end else begin
              cell_ctl.op   = CELL_LOAD;
              cell_ctl.pos  = POS_W'(count_r);
              orc_nxt       = next_rcpt_r;
              ost_nxt       = STATUS_OK;
              count_nxt     = count_r + 1'b1;
              ocnt_nxt      = count_r + 1'b1;
              next_rcpt_nxt = (rcpt_inc == '0) ? RECEIPT_WIDTH'(1) : rcpt_inc;
            end
          end else begin
            key_nxt = in_receipt;
            if (count_r == '0) begin
              ov_nxt    = 1'b1;
              orc_nxt   = '0;
              oitem_nxt = '0;
              ost_nxt   = STATUS_NOT_FOUND;
              ocnt_nxt  = count_r;
            end else begin
              state_nxt = ST_SCAN;
              steps_nxt = count_r;
              found_nxt = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        // head leaves cell 0 each cycle; kept entries re-enter at the tail
        if (match) begin
          cell_ctl.op = CELL_DROP;
          found_nxt   = 1'b1;
          hit_nxt     = head_item;
          count_nxt   = count_r - 1'b1;
        end else begin
          cell_ctl.op  = CELL_ROTATE;
          cell_ctl.pos = POS_W'(count_r - 1'b1);
        end
        steps_nxt = steps_r - 1'b1;
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
          ov_nxt    = 1'b1;
          orc_nxt   = '0;
          ost_nxt   = (found_r || match) ? STATUS_OK : STATUS_NOT_FOUND;
          oitem_nxt = match ? head_item : (found_r ? hit_r : '0);
          ocnt_nxt  = count_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      next_rcpt_r <= RECEIPT_WIDTH'(1);
      found_r     <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      next_rcpt_r <= next_rcpt_nxt;
      found_r     <= found_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    hit_r   <= hit_nxt;
    orc_r   <= orc_nxt;
    oitem_r <= oitem_nxt;
    ost_r   <= ost_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_valid          = ov_r;
  assign out_issued_receipt = orc_r;
  assign out_removed_item   = oitem_r;
  assign out_status         = ost_r;
  assign out_item_count     = ocnt_r;
  assign out_is_empty       = (ocnt_r == '0);

  `RTS_ASSERT_NOW(a_rcpt_nonzero, 1'b1, next_rcpt_r != '0)
  `RTS_ASSERT_NOW(a_scan_bounds, state_r == ST_SCAN, (steps_r != '0) && (count_r >= steps_r))
  `RTS_ASSERT_NOW(a_full_status, ov_r && (ost_r == STATUS_FULL), count_r == CAP_CNT)
  `RTS_ASSERT_NEXT(a_insert_grows,
    (state_r == ST_IDLE) && start && (in_kind == KIND_INSERT) && (count_r != CAP_CNT),
    (count_r == $past(count_r) + 1'b1) && ov_r && (ost_r == STATUS_OK))

endmodule
`default_nettype wire

// ----- hdl/receipt_tagged_store.sv -----
// receipt store top: sequencer plus a chain of slot cells
// insert, or remove from an empty store: strobe in the cycle after the transfer, one per cycle
// remove with items held: busy while each held item passes the head, strobe and next transfer in the cycle after
// busy is high during the scan; the head compare on cell 0's receipt steers the chain
// out_valid is a one-cycle strobe, the receiver cannot stall it
// synchronous active-low reset: count 0, next receipt 1, slot contents left as they are
`default_nettype none
module receipt_tagged_store #(
  parameter int CAPACITY      = rts_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH    = rts_pkg::ITEM_WIDTH_DEF,
  parameter int RECEIPT_WIDTH = rts_pkg::RECEIPT_WIDTH_DEF,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire                      in_kind,
  input  wire  [ITEM_WIDTH-1:0]    in_item_value,
  input  wire  [RECEIPT_WIDTH-1:0] in_receipt,
  output logic                     out_valid,
  output logic [RECEIPT_WIDTH-1:0] out_issued_receipt,
  output logic [ITEM_WIDTH-1:0]    out_removed_item,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_item_count,
  output logic                     out_is_empty
);
  import rts_pkg::*;

  // per-slot contents as seen by the neighbors
  logic [ITEM_WIDTH-1:0]    slot_item [CAPACITY];
  logic [RECEIPT_WIDTH-1:0] slot_rcpt [CAPACITY];

  // broadcast command to all cells: hold, load at pos, rotate into pos, drop head
  cell_ctl_t                cell_ctl;
  logic [RECEIPT_WIDTH-1:0] load_rcpt;

  rts_ctrl #(
    .CAPACITY      (CAPACITY),
    .ITEM_WIDTH    (ITEM_WIDTH),
    .RECEIPT_WIDTH (RECEIPT_WIDTH),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_receipt         (in_receipt),
    .head_item          (slot_item[0]),
    .head_rcpt          (slot_rcpt[0]),
    .cell_ctl           (cell_ctl),
    .load_rcpt          (load_rcpt),
    .out_valid          (out_valid),
    .out_issued_receipt (out_issued_receipt),
    .out_removed_item   (out_removed_item),
    .out_status         (out_status),
    .out_item_count     (out_item_count),
    .out_is_empty       (out_is_empty)
  );

  // cell i takes cell i+1 on a shift; the last cell recirculates its own value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0]    up_item;
    logic [RECEIPT_WIDTH-1:0] up_rcpt;

    if (i == CAPACITY - 1) begin : g_last
      assign up_item = slot_item[i];
      assign up_rcpt = slot_rcpt[i];
    end else begin : g_mid
      assign up_item = slot_item[i+1];
      assign up_rcpt = slot_rcpt[i+1];
    end

    rts_cell #(
      .IDX           (i),
      .ITEM_WIDTH    (ITEM_WIDTH),
      .RECEIPT_WIDTH (RECEIPT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .load_item (in_item_value),
      .load_rcpt (load_rcpt),
      .head_item (slot_item[0]),
      .head_rcpt (slot_rcpt[0]),
      .up_item   (up_item),
      .up_rcpt   (up_rcpt),
      .item      (slot_item[i]),
      .rcpt      (slot_rcpt[i])
    );
  end

endmodule
`default_nettype wire

// ----- bench/receipt_tagged_store_tb.sv -----
// self-checking testbench of the receipt store: directed table and random bursts
`default_nettype none
module receipt_tagged_store_tb;
  import rts_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int ITEM_W   = ITEM_WIDTH_DEF;
  localparam int RCPT_W   = RECEIPT_WIDTH_DEF;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // a remove scans every held item, so this covers the longest operation
  localparam int SETTLE_CYCLES = CAPACITY + 4;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DIR_ROWS      = 28;
  localparam int REPORT_MAX    = 10;

  // one result of the store, field by field
  typedef struct packed {
    logic [RCPT_W-1:0] rc;
    logic [ITEM_W-1:0] item;
    logic [1:0]        st;
    logic [CNT_W-1:0]  cnt;
    logic              empty;
  } outcome_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic              kind;
    logic [ITEM_W-1:0] value;
    logic [RCPT_W-1:0] rcpt;
    bit                typed;
    outcome_t          want;
  } op_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_kind;
  logic [ITEM_W-1:0] in_item_value;
  logic [RCPT_W-1:0] in_receipt;
  logic              out_valid;
  logic [RCPT_W-1:0] out_issued_receipt;
  logic [ITEM_W-1:0] out_removed_item;
  logic [1:0]        out_status;
  logic [CNT_W-1:0]  out_item_count;
  logic              out_is_empty;

  receipt_tagged_store #(
    .CAPACITY      (CAPACITY),
    .ITEM_WIDTH    (ITEM_W),
    .RECEIPT_WIDTH (RCPT_W)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_item_value      (in_item_value),
    .in_receipt         (in_receipt),
    .out_valid          (out_valid),
    .out_issued_receipt (out_issued_receipt),
    .out_removed_item   (out_removed_item),
    .out_status         (out_status),
    .out_item_count     (out_item_count),
    .out_is_empty       (out_is_empty)
  );

  // 20 time unit clock, first rising edge at 10
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow of the store: entries in insertion order, count and receipt counter
  logic [ITEM_W-1:0] shadow_items [CAPACITY];
  logic [RCPT_W-1:0] shadow_rcpts [CAPACITY];
  int                shadow_held;
  logic [RCPT_W-1:0] shadow_next_rcpt;

  // results still owed by the store, oldest first
  outcome_t owed_results [$];
  int       mismatch_cnt;
  int       cycles_run;

  op_row_t  dir_rows [DIR_ROWS];

  // apply one operation to the shadow store and return the result it must give
  function automatic outcome_t store_apply(input logic kind, input logic [ITEM_W-1:0] value,
                                           input logic [RCPT_W-1:0] rcpt);
    outcome_t r;
    int       hit;
    r   = '0;
    hit = -1;
    if (kind == KIND_INSERT) begin
      if (shadow_held >= CAPACITY) begin
        // full: nothing changes, no receipt handed out
        r.st = STATUS_FULL;
      end else begin
        r.rc                      = shadow_next_rcpt;
        r.st                      = STATUS_OK;
        shadow_items[shadow_held] = value;
        shadow_rcpts[shadow_held] = shadow_next_rcpt;
        shadow_held++;
        // counter wraps past the top value to 1, never to 0
        shadow_next_rcpt = shadow_next_rcpt + 1'b1;
        if (shadow_next_rcpt == '0) shadow_next_rcpt = RCPT_W'(1);
      end
    end else begin
      // oldest match wins, which matters once receipts repeat after a wrap
      for (int i = 0; i < shadow_held; i++) begin
        if (hit < 0 && shadow_rcpts[i] == rcpt) hit = i;
      end
      if (hit < 0) begin
        r.st = STATUS_NOT_FOUND;
      end else begin
        r.item = shadow_items[hit];
        r.st   = STATUS_OK;
        // close the gap, order of the later entries kept
        for (int j = hit; j < shadow_held - 1; j++) begin
          shadow_items[j] = shadow_items[j + 1];
          shadow_rcpts[j] = shadow_rcpts[j + 1];
        end
        shadow_held--;
      end
    end
    r.cnt   = CNT_W'(shadow_held);
    r.empty = (shadow_held == 0);
    return r;
  endfunction

  function automatic op_row_t mk_row(input logic kind, input logic [ITEM_W-1:0] value,
                                     input logic [RCPT_W-1:0] rcpt, input bit typed,
                                     input outcome_t want);
    op_row_t row;
    row.kind  = kind;
    row.value = value;
    row.rcpt  = rcpt;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // item data, with the all-zero and all-one extremes turning up often
  function automatic logic [ITEM_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ITEM_W'($urandom);
  endfunction

  // present one operation and hold it until the store takes it; the shadow is
  // updated once an edge leaves busy low, so the next pick sees the new state
  task automatic issue_op(input logic kind, input logic [ITEM_W-1:0] value,
                          input logic [RCPT_W-1:0] rcpt, input bit typed, input outcome_t want);
    outcome_t predicted;
    start         <= 1'b1;
    in_kind       <= kind;
    in_item_value <= value;
    in_receipt    <= rcpt;
    do @(posedge clk); while (busy);
    predicted = store_apply(kind, value, rcpt);
    owed_results.insert(owed_results.size(), typed ? want : predicted);
  endtask

  task automatic send_insert(input logic [ITEM_W-1:0] value);
    issue_op(KIND_INSERT, value, RCPT_W'($urandom), 1'b0, '0);
  endtask

  task automatic send_remove(input logic [RCPT_W-1:0] rcpt);
    issue_op(KIND_REMOVE, ITEM_W'($urandom), rcpt, 1'b0, '0);
  endtask

  // sender gap: start low, junk on the fields that the store must ignore
  task automatic pause_sender(input int n);
    start         <= 1'b0;
    in_kind       <= 1'($urandom);
    in_item_value <= ITEM_W'($urandom);
    in_receipt    <= RCPT_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // hold off until every owed result has come, then let the store settle
  task automatic settle_store();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: one strobe per result, matched against the oldest owed one
  always @(posedge clk) begin : result_check
    outcome_t want;
    outcome_t got;
    if (rst_n && out_valid) begin
      got = '{out_issued_receipt, out_removed_item, out_status, out_item_count, out_is_empty};
      if (owed_results.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX)
          $display("result with nothing owed: rc=%h item=%h st=%0d cnt=%0d empty=%0b",
                   got.rc, got.item, got.st, got.cnt, got.empty);
        mismatch_cnt++;
      end else begin
        want = owed_results.pop_front();
        if (got.rc !== want.rc || got.item !== want.item || got.st !== want.st ||
            got.cnt !== want.cnt || got.empty !== want.empty) begin
          if (mismatch_cnt < REPORT_MAX) begin
            $display("mismatch: want rc=%h item=%h st=%0d cnt=%0d empty=%0b",
                     want.rc, want.item, want.st, want.cnt, want.empty);
            $display("          got  rc=%h item=%h st=%0d cnt=%0d empty=%0b",
                     got.rc, got.item, got.st, got.cnt, got.empty);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int done;
    int burst_len;
    int insert_pct;
    int gap;
    int sel;
    bit paused;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = KIND_INSERT;
    in_item_value    = '0;
    in_receipt       = '0;
    mismatch_cnt     = 0;
    cycles_run       = 0;
    shadow_held      = 0;
    shadow_next_rcpt = RCPT_W'(1);
    paused           = 1'b0;

    // directed table: typed results where they are plain, the rest predicted
    dir_rows[0] = mk_row(KIND_REMOVE, '1, 16'h0000, 1'b1,
                         '{16'd0, 32'd0, STATUS_NOT_FOUND, 5'd0, 1'b1});
    dir_rows[1] = mk_row(KIND_INSERT, 32'h0000_0000, 16'hFFFF, 1'b1,
                         '{16'd1, 32'd0, STATUS_OK, 5'd1, 1'b0});
    dir_rows[2] = mk_row(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000, 1'b1,
                         '{16'd2, 32'd0, STATUS_OK, 5'd2, 1'b0});
    // receipt 0 is never issued
    dir_rows[3] = mk_row(KIND_REMOVE, '0, 16'h0000, 1'b1,
                         '{16'd0, 32'd0, STATUS_NOT_FOUND, 5'd2, 1'b0});
    dir_rows[4] = mk_row(KIND_REMOVE, '1, 16'hFFFF, 1'b1,
                         '{16'd0, 32'd0, STATUS_NOT_FOUND, 5'd2, 1'b0});
    dir_rows[5] = mk_row(KIND_REMOVE, '1, 16'h0001, 1'b1,
                         '{16'd0, 32'h0000_0000, STATUS_OK, 5'd1, 1'b0});
    // same receipt twice: second try finds nothing
    dir_rows[6] = mk_row(KIND_REMOVE, '0, 16'h0001, 1'b1,
                         '{16'd0, 32'd0, STATUS_NOT_FOUND, 5'd1, 1'b0});
    dir_rows[7] = mk_row(KIND_REMOVE, '0, 16'h0002, 1'b1,
                         '{16'd0, 32'hFFFF_FFFF, STATUS_OK, 5'd0, 1'b1});
    // fill to capacity, receipts 3 up to 18
    for (int k = 0; k < CAPACITY; k++)
      dir_rows[8 + k] = mk_row(KIND_INSERT, (k % 2 ? 32'hAAAA_AAAA : 32'h5555_5555) ^ k,
                               RCPT_W'(k), 1'b0, '0);
    // insert into a full store changes nothing
    dir_rows[24] = mk_row(KIND_INSERT, 32'h1234_5678, 16'h0000, 1'b1,
                          '{16'd0, 32'd0, STATUS_FULL, 5'd16, 1'b0});
    // remove from the middle, the head and the tail
    dir_rows[25] = mk_row(KIND_REMOVE, '0, 16'd10, 1'b0, '0);
    dir_rows[26] = mk_row(KIND_REMOVE, '1, 16'd3, 1'b0, '0);
    dir_rows[27] = mk_row(KIND_REMOVE, '0, 16'd18, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++)
      issue_op(dir_rows[k].kind, dir_rows[k].value, dir_rows[k].rcpt,
               dir_rows[k].typed, dir_rows[k].want);

    // random bursts; the insert share moves between bursts so the store
    // swings between empty and full
    done = 0;
    while (done < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 40);
      sel       = $urandom_range(0, 2);
      insert_pct = (sel == 0) ? 15 : (sel == 1) ? 50 : 85;
      for (int b = 0; b < burst_len && done < RANDOM_ITEMS; b++) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          send_insert(pick_value());
        end else if (shadow_held > 0 && $urandom_range(0, 9) != 0) begin
          // well-formed remove of an item that is held somewhere in the store
          send_remove(shadow_rcpts[$urandom_range(0, shadow_held - 1)]);
        end else begin
          // stray receipt, usually not found
          sel = $urandom_range(0, 9);
          send_remove(sel == 0 ? RCPT_W'(0) : sel == 1 ? '1 : RCPT_W'($urandom));
        end
        done++;
        // once halfway, wait for the store to catch up completely
        if (!paused && done >= RANDOM_ITEMS / 2) begin
          settle_store();
          paused = 1'b1;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) pause_sender(gap);
    end

    // drain whatever is left, oldest first
    settle_store();
    while (shadow_held > 0) send_remove(shadow_rcpts[0]);

    settle_store();
    if (mismatch_cnt == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
